/* sv/assert_macros.svh */
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define PSBT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define PSBT_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/psbt_pkg.sv */
// Shared widths, types and helper functions for the swept blade containment test.
package psbt_pkg;

   // Coordinate format and the widths that follow from it.
   localparam int COORD_W   = 20;
   localparam int QUERY_W   = 20;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int CROSS_W   = PROD_W + 1;
   localparam int CLO_W     = CROSS_W / 2;
   localparam int CHI_W     = CROSS_W - CLO_W;
   localparam int PLO_W     = DIFF_W + CLO_W + 1;
   localparam int PHI_W     = DIFF_W + CHI_W;
   localparam int LSUM_W    = PLO_W + 2;
   localparam int HSUM_W    = PHI_W + 2;
   localparam int DET_W     = DIFF_W + CROSS_W + 2;

   // Corner registers and the control port.
   localparam int NUM_CORNERS  = 8;
   localparam int CORNER_IDX_W = 3;
   localparam int CORNER_REG_W = 60;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_LSB  = 3;
   localparam int CSR_ADDR_W   = CSR_IDX_LSB + CORNER_IDX_W;

   // Stream widths.
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 8;

   // Pipeline shape.
   localparam int NUM_DETS   = 6;
   localparam int NUM_AXES   = 3;
   localparam int NUM_PRODS  = 2 * NUM_AXES;
   localparam int PIPE_DEPTH = 7;
   localparam int INFLIGHT_W = $clog2(PIPE_DEPTH + 1);

   typedef logic [CORNER_IDX_W-1:0] corner_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } coord_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] z;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] x;
   } dvec_type;

   // Corner numbering: old face corners are 0..3, new face corners are 4..7.
   // Each orientation test uses the plane through corners A, B and C.
   localparam corner_idx_type DET_A [NUM_DETS] = '{3'd0, 3'd4, 3'd0, 3'd3, 3'd0, 3'd1};
   localparam corner_idx_type DET_B [NUM_DETS] = '{3'd1, 3'd5, 3'd4, 3'd7, 3'd4, 3'd5};
   localparam corner_idx_type DET_C [NUM_DETS] = '{3'd2, 3'd6, 3'd5, 3'd6, 3'd7, 3'd6};

   function automatic coord_type unpack_corner(input logic [CORNER_REG_W-1:0] r);
      logic [3*COORD_W-1:0] f;
      coord_type c;
      f   = (3*COORD_W)'(r);
      c.x = $signed(f[COORD_W-1:0]);
      c.y = $signed(f[2*COORD_W-1:COORD_W]);
      c.z = $signed(f[3*COORD_W-1:2*COORD_W]);
      return c;
   endfunction

   function automatic dvec_type vec_sub(input coord_type a, input coord_type b);
      dvec_type r;
      r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
      r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
      r.z = DIFF_W'(a.z) - DIFF_W'(b.z);
      return r;
   endfunction

endpackage

/* sv/point_in_swept_blade_test.sv */
// Swept blade containment test: six pipelined orientation determinants and their sign pairs.
// Throughput: one item per cycle while the result side takes results; each of the seven
// register stages takes a new item whenever it is empty or its successor moves on, so
// bubbles close up and stalls lose nothing. The seven stages set the latency, the first
// loading at the accepting edge; the clock is set by the widest step, the 21 by 22 bit
// partial products. Reset (synchronous, active high) clears the stage valid bits and all
// eight corner registers.
module point_in_swept_blade_test import psbt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // Query items.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // query_x [19:0], query_y [39:20], query_z [59:40]
   // Result items.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // inside_res [0]
   // Corner register port.
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   // ---------------------------------------------------------------------------------------
   // Corner registers. Register i sits at byte address 8*i; the low address bits are
   // ignored. Reads return the stored 60 bits with zeros above.
   // ---------------------------------------------------------------------------------------
   logic [CORNER_REG_W-1:0] corner_ff [NUM_CORNERS];
   corner_idx_type          csr_idx;
   logic                    csr_wr;

   assign csr_idx    = csr_paddr[CSR_IDX_LSB +: CORNER_IDX_W];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(corner_ff[csr_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CORNERS; i++) begin
            corner_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         corner_ff[csr_idx] <= csr_pwdata[CORNER_REG_W-1:0];
      end
   end

   coord_type corner [NUM_CORNERS];

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         corner[i] = unpack_corner(corner_ff[i]);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage control. Each stage loads when it is empty or when the stage after it loads.
   // Index 0 is the first stage, index PIPE_DEPTH-1 is the output register.
   // ---------------------------------------------------------------------------------------
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;
   logic [PIPE_DEPTH-1:0] stage_ld;

   always_comb begin
      stage_ld[PIPE_DEPTH-1] = ~vld_ff[PIPE_DEPTH-1] | rsp_tready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         stage_ld[k] = ~vld_ff[k] | stage_ld[k+1];
      end
   end

   assign req_tready = stage_ld[0] & ~reset;
   assign vld_in     = {vld_ff[PIPE_DEPTH-2:0], req_tvalid & ~reset};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (stage_ld[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // The query point, taken from the low coordinate bits of each field.
   coord_type query;

   assign query.x = $signed(COORD_W'(req_tdata[0 +: QUERY_W]));
   assign query.y = $signed(COORD_W'(req_tdata[QUERY_W +: QUERY_W]));
   assign query.z = $signed(COORD_W'(req_tdata[2*QUERY_W +: QUERY_W]));

   // ---------------------------------------------------------------------------------------
   // Six orientation determinants det[B-A, C-A, P-A], one lane each.
   //   stage 1: P-A
   //   stage 2: the six products of the cross product (C-A) x (P-A)
   //   stage 3: the cross product components
   //   stage 4: (B-A) times each component, split into a low and a high partial product
   //   stage 5: the low and high partial sums
   //   stage 6: the full determinant and its strict sign
   // The edge vectors B-A and C-A depend on the corners only; they are registered so
   // that the corner decode stays off the multiplier paths. They are first needed in
   // stage 2, after the P-A register, so an item accepted after a corner write uses new edges.
   // ---------------------------------------------------------------------------------------
   dvec_type                  edge_b_ff  [NUM_DETS];
   dvec_type                  edge_c_ff  [NUM_DETS];
   dvec_type                  pd_ff      [NUM_DETS];
   logic signed [PROD_W-1:0]  prod_ff    [NUM_DETS][NUM_PRODS];
   logic signed [CROSS_W-1:0] cross_ff   [NUM_DETS][NUM_AXES];
   logic signed [PLO_W-1:0]   plo_ff     [NUM_DETS][NUM_AXES];
   logic signed [PHI_W-1:0]   phi_ff     [NUM_DETS][NUM_AXES];
   logic signed [LSUM_W-1:0]  lsum_ff    [NUM_DETS];
   logic signed [HSUM_W-1:0]  hsum_ff    [NUM_DETS];
   logic [NUM_DETS-1:0]       det_pos;
   logic [NUM_DETS-1:0]       pos_ff;
   logic                      inside_ff;

   for (genvar d = 0; d < NUM_DETS; d++) begin : g_det
      dvec_type                 eb;
      dvec_type                 ec;
      dvec_type                 pd;
      logic signed [DIFF_W-1:0] bvec [NUM_AXES];
      logic signed [DET_W-1:0]  det_sum;

      assign eb = edge_b_ff[d];
      assign ec = edge_c_ff[d];
      assign pd = pd_ff[d];

      assign bvec[0] = eb.x;
      assign bvec[1] = eb.y;
      assign bvec[2] = eb.z;

      always_ff @(posedge clock) begin
         edge_b_ff[d] <= vec_sub(corner[DET_B[d]], corner[DET_A[d]]);
         edge_c_ff[d] <= vec_sub(corner[DET_C[d]], corner[DET_A[d]]);
      end

      always_ff @(posedge clock) begin
         if (stage_ld[0]) begin
            pd_ff[d] <= vec_sub(query, corner[DET_A[d]]);
         end
         if (stage_ld[1]) begin
            prod_ff[d][0] <= ec.y * pd.z;
            prod_ff[d][1] <= ec.z * pd.y;
            prod_ff[d][2] <= ec.z * pd.x;
            prod_ff[d][3] <= ec.x * pd.z;
            prod_ff[d][4] <= ec.x * pd.y;
            prod_ff[d][5] <= ec.y * pd.x;
         end
         if (stage_ld[2]) begin
            for (int j = 0; j < NUM_AXES; j++) begin
               cross_ff[d][j] <= CROSS_W'(prod_ff[d][2*j]) - CROSS_W'(prod_ff[d][2*j+1]);
            end
         end
         if (stage_ld[3]) begin
            for (int j = 0; j < NUM_AXES; j++) begin
               // Low half is taken as unsigned, high half carries the sign.
               plo_ff[d][j] <= bvec[j] * $signed({1'b0, cross_ff[d][j][CLO_W-1:0]});
               phi_ff[d][j] <= bvec[j] * $signed(cross_ff[d][j][CROSS_W-1:CLO_W]);
            end
         end
         if (stage_ld[4]) begin
            lsum_ff[d] <= LSUM_W'(plo_ff[d][0]) + LSUM_W'(plo_ff[d][1])
                        + LSUM_W'(plo_ff[d][2]);
            hsum_ff[d] <= HSUM_W'(phi_ff[d][0]) + HSUM_W'(phi_ff[d][1])
                        + HSUM_W'(phi_ff[d][2]);
         end
      end

      // A determinant of exactly zero counts as not positive.
      assign det_sum    = (DET_W'(hsum_ff[d]) <<< CLO_W) + DET_W'(lsum_ff[d]);
      assign det_pos[d] = ~det_sum[DET_W-1] & (det_sum != '0);
   end

   // The point is inside only if each pair of planes sees it on opposite sides:
   // old face against new face, and the two pairs of side planes.
   always_ff @(posedge clock) begin
      if (stage_ld[5]) begin
         pos_ff <= det_pos;
      end
      if (stage_ld[6]) begin
         inside_ff <= (pos_ff[0] ^ pos_ff[1]) & (pos_ff[2] ^ pos_ff[3])
                    & (pos_ff[4] ^ pos_ff[5]);
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = RSP_DATA_W'(inside_ff);

endmodule

/* sv/psbt_checker.sv */
// Port-level checker for the swept blade containment test, bound to the top level.
`include "assert_macros.svh"

module psbt_checker import psbt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,   // query_x [19:0], query_y [39:20], query_z [59:40]
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,   // inside_res [0]
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   // Items accepted whose results have not yet been taken.
   logic [INFLIGHT_W-1:0] inflight_ff;
   logic                  in_acc;
   logic                  out_acc;
   logic                  csr_wr;

   assign in_acc  = req_tvalid & req_tready;
   assign out_acc = rsp_tvalid & rsp_tready;
   assign csr_wr  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + INFLIGHT_W'(in_acc) - INFLIGHT_W'(out_acc);
      end
   end

   `PSBT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `PSBT_ASSERT(a_no_orphan, clock, reset, rsp_tvalid |-> inflight_ff != '0, "result without an accepted item")
   `PSBT_ASSERT(a_depth, clock, reset, inflight_ff <= INFLIGHT_W'(PIPE_DEPTH), "more items in flight than stages")
   `PSBT_ASSERT_NR(a_reset_flush, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `PSBT_ASSERT(a_readback, clock, reset, $past(csr_wr && !reset) && !csr_pwrite && csr_paddr == $past(csr_paddr) |-> csr_prdata == CSR_DATA_W'($past(csr_pwdata[CORNER_REG_W-1:0])), "corner readback mismatch")

endmodule

bind point_in_swept_blade_test psbt_checker u_psbt_checker (.*);

/* dv/point_in_swept_blade_test_test.sv */
// Self-checking testbench for the swept blade containment test block.
module point_in_swept_blade_test_test;
   import psbt_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int IDLE_PCT       = 14;
   localparam int HOLD_CYCLES    = 64;
   localparam int RUN_LEN        = 125;
   localparam int SETTLE_CYCLES  = 16;
   localparam int MAX_REPORTS    = 10;
   localparam int TIMEOUT_CYCLES = 400000;

   localparam int COORD_MIN = -(1 << (COORD_W - 1));
   localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
   localparam logic signed [COORD_W-1:0] Q_MIN = 20'sh80000;
   localparam logic signed [COORD_W-1:0] Q_MAX = 20'sh7FFFF;

   // Corner register map, in address order.
   typedef enum int {
      OLD_CORNER_0, OLD_CORNER_1, OLD_CORNER_2, OLD_CORNER_3,
      NEW_CORNER_0, NEW_CORNER_1, NEW_CORNER_2, NEW_CORNER_3
   } corner_reg_type;

   // Face setups used by the directed probes.
   typedef enum logic [1:0] {CFG_ZERO, CFG_UNIT_BOX, CFG_FULL_BOX, CFG_FLAT} face_setup_type;

   // A directed probe either carries its verdict or leaves it to the predictor.
   typedef enum logic [1:0] {WANT_OUT, WANT_IN, WANT_MODEL} want_type;

   // Shapes of the random runs.
   typedef enum int {
      RUN_JITTER_BOX, RUN_SHARP_BOX, RUN_FULL_BOX, RUN_SCATTER, RUN_SKEW_BOX, RUN_WIDE_JITTER
   } run_kind_type;

   typedef struct packed {
      face_setup_type            setup;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      want_type                  want;
   } probe_row_type;

   typedef struct {
      coord_type query;
      bit        is_in;
   } verdict_type;

   localparam int N_PROBES = 21;

   // Directed probes. Right after reset every corner is zero, so every point is outside.
   // The unit box spans -1.0 to +1.0 on every axis. A point on a face is inside on the
   // x = -1.0, y = +1.0 and z = +1.0 faces and outside on the other three.
   // The full box spans the whole coordinate range, which gives the widest determinants.
   // The flat setup puts all eight corners on one line, so every determinant is zero.
   localparam probe_row_type PROBES [N_PROBES] = '{
      '{CFG_ZERO,     20'sd0,       20'sd0,       20'sd0,       WANT_OUT},
      '{CFG_ZERO,     Q_MAX,        Q_MAX,        Q_MAX,        WANT_OUT},
      '{CFG_ZERO,     Q_MIN,        Q_MIN,        Q_MIN,        WANT_OUT},
      '{CFG_UNIT_BOX, 20'sd0,       20'sd0,       20'sd0,       WANT_IN},
      '{CFG_UNIT_BOX, 20'sd255,     20'sd255,     20'sd255,     WANT_IN},
      '{CFG_UNIT_BOX, -20'sd255,    -20'sd255,    -20'sd255,    WANT_IN},
      '{CFG_UNIT_BOX, 20'sd256,     20'sd0,       20'sd0,       WANT_OUT},
      '{CFG_UNIT_BOX, 20'sd0,       20'sd0,       -20'sd256,    WANT_OUT},
      '{CFG_UNIT_BOX, 20'sd0,       20'sd257,     20'sd0,       WANT_OUT},
      '{CFG_UNIT_BOX, Q_MIN,        20'sd0,       20'sd0,       WANT_OUT},
      '{CFG_UNIT_BOX, 20'sd100,     -20'sd37,     20'sd12,      WANT_MODEL},
      '{CFG_UNIT_BOX, 20'sh00055,   -20'sd170,    20'sd3,       WANT_MODEL},
      '{CFG_FULL_BOX, 20'sd0,       20'sd0,       20'sd0,       WANT_IN},
      '{CFG_FULL_BOX, Q_MIN,        20'sd0,       20'sd0,       WANT_IN},
      '{CFG_FULL_BOX, Q_MAX,        Q_MAX,        Q_MAX,        WANT_OUT},
      '{CFG_FULL_BOX, -20'sd524287, 20'sd524286,  -20'sd524287, WANT_IN},
      '{CFG_FULL_BOX, 20'sh55555,   20'shAAAAA,   20'sh2AAAA,   WANT_MODEL},
      '{CFG_FULL_BOX, -20'sd1,      -20'sd1,      -20'sd1,      WANT_IN},
      '{CFG_FLAT,     20'sd0,       20'sd0,       20'sd0,       WANT_OUT},
      '{CFG_FLAT,     20'sd50,      20'sd100,     20'sd150,     WANT_OUT},
      '{CFG_FLAT,     Q_MAX,        Q_MIN,        20'sd7,       WANT_OUT}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // query_x [19:0], query_y [39:20], query_z [59:40]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // inside_res [0]
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Our own copy of the corner registers, updated as each write lands.
   logic [CORNER_REG_W-1:0] corner_cfg [NUM_CORNERS];

   // Verdicts for queries that the block has taken but not yet answered, oldest first.
   verdict_type pending_verdicts [$];

   int mismatches;
   bit steady;     // both sides stop idling while set
   bit hold_req;   // asks the result side for one long hold-off

   // Bounds of the box that the current corners were built from; queries cluster around it.
   int box_lo [3];
   int box_hi [3];

   point_in_swept_blade_test u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // True when det[B-A, C-A, P-A] is strictly positive. Every operand is widened to 96 bits
   // before any arithmetic, so the products are exact and a zero determinant reads as false.
   function automatic bit above_plane(input coord_type a, input coord_type b,
                                      input coord_type c, input coord_type p);
      logic signed [95:0] bx, by, bz, cx, cy, cz, px, py, pz, k0, k1, k2, det;
      bx  = $signed(b.x) - $signed(a.x);
      by  = $signed(b.y) - $signed(a.y);
      bz  = $signed(b.z) - $signed(a.z);
      cx  = $signed(c.x) - $signed(a.x);
      cy  = $signed(c.y) - $signed(a.y);
      cz  = $signed(c.z) - $signed(a.z);
      px  = $signed(p.x) - $signed(a.x);
      py  = $signed(p.y) - $signed(a.y);
      pz  = $signed(p.z) - $signed(a.z);
      k0  = cy * pz - cz * py;
      k1  = cz * px - cx * pz;
      k2  = cx * py - cy * px;
      det = bx * k0 + by * k1 + bz * k2;
      return det > 0;
   endfunction

   // The point is inside only when it falls on opposite sides of each plane pair:
   // old face against new face, and the two pairs of side walls.
   function automatic bit blade_contains(input coord_type q);
      coord_type o [4];
      coord_type n [4];
      for (int i = 0; i < 4; i++) begin
         o[i] = coord_type'(corner_cfg[OLD_CORNER_0 + i][3*COORD_W-1:0]);
         n[i] = coord_type'(corner_cfg[NEW_CORNER_0 + i][3*COORD_W-1:0]);
      end
      return (above_plane(o[0], o[1], o[2], q) != above_plane(n[0], n[1], n[2], q)) &&
             (above_plane(o[0], n[0], n[1], q) != above_plane(o[3], n[3], n[2], q)) &&
             (above_plane(o[0], n[0], n[3], q) != above_plane(o[1], n[1], n[2], q));
   endfunction

   function automatic int clamp_coord(input int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic int wobble(input int v, input int jit);
      return clamp_coord(v + int'($urandom_range(2 * jit)) - jit);
   endfunction

   function automatic logic [CORNER_REG_W-1:0] pack_corner(input int x, input int y, input int z);
      return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
   endfunction

   // Most queries land in or near the current box, some sit exactly on one of its
   // bounding planes, and the rest are drawn from the whole coordinate range.
   function automatic coord_type next_query();
      coord_type q;
      int c [3];
      int m;
      int pick;
      int ax;
      pick = $urandom_range(99);
      for (int a = 0; a < 3; a++) begin
         if (pick >= 80) begin
            c[a] = int'($urandom_range(20'hFFFFF)) + COORD_MIN;
         end else begin
            m    = (box_hi[a] - box_lo[a]) / 8 + 2;
            c[a] = clamp_coord(box_lo[a] - m +
                               int'($urandom_range(box_hi[a] - box_lo[a] + 2 * m)));
         end
      end
      if (pick < 15) begin
         ax    = $urandom_range(2);
         c[ax] = $urandom_range(1) ? box_hi[ax] : box_lo[ax];
      end
      q.x = c[0][COORD_W-1:0];
      q.y = c[1][COORD_W-1:0];
      q.z = c[2][COORD_W-1:0];
      return q;
   endfunction

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // One write and one read-back of a corner register, after which the bus is left idle.
   // The upper bits of the write data lie beyond the register and carry noise.
   task automatic program_corner(input int idx, input logic [CORNER_REG_W-1:0] val);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] readback;
      wdata                    = {$urandom, $urandom};
      wdata[CORNER_REG_W-1:0]  = val;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx << CSR_IDX_LSB);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      @(posedge clock);
      corner_cfg[idx] = val;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      readback = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[CORNER_REG_W-1:0] !== val)
         flag_error($sformatf("corner %0d reads back %h, wrote %h",
                              idx, readback[CORNER_REG_W-1:0], val));
      @(posedge clock);
   endtask

   // Builds both faces from the current box: the old face at the low z bound, the new face
   // at the high one, each corner moved by up to jit in every coordinate.
   task automatic load_box(input int jit);
      int x, y;
      for (int i = 0; i < 4; i++) begin
         x = (i == 1 || i == 2) ? box_hi[0] : box_lo[0];
         y = (i >= 2) ? box_hi[1] : box_lo[1];
         program_corner(OLD_CORNER_0 + i,
                        pack_corner(wobble(x, jit), wobble(y, jit), wobble(box_lo[2], jit)));
         program_corner(NEW_CORNER_0 + i,
                        pack_corner(wobble(x, jit), wobble(y, jit), wobble(box_hi[2], jit)));
      end
   endtask

   // Mostly small boxes; now and then one that spans most of the range.
   task automatic pick_box();
      int w;
      for (int a = 0; a < 3; a++) begin
         w         = ($urandom_range(9) == 0) ? int'($urandom_range(600000, 1))
                                              : int'($urandom_range(2000, 1));
         box_lo[a] = int'($urandom_range(1048575 - w)) + COORD_MIN;
         box_hi[a] = box_lo[a] + w;
      end
   endtask

   task automatic use_full_range();
      box_lo = '{COORD_MIN, COORD_MIN, COORD_MIN};
      box_hi = '{COORD_MAX, COORD_MAX, COORD_MAX};
   endtask

   task automatic apply_setup(input face_setup_type setup);
      case (setup)
         CFG_UNIT_BOX: begin
            box_lo = '{-256, -256, -256};
            box_hi = '{256, 256, 256};
            load_box(0);
         end
         CFG_FULL_BOX: begin
            use_full_range();
            load_box(0);
         end
         CFG_FLAT: begin
            for (int i = OLD_CORNER_0; i <= NEW_CORNER_3; i++)
               program_corner(i, pack_corner(50 * i, 100 * i, 150 * i));
         end
         default: ;
      endcase
   endtask

   // Offers one query, after idle cycles drawn one at a time, and records its verdict at the
   // edge where the block takes it. The handshake is judged at the falling edge, when every
   // input and output has settled for the coming rising edge.
   task automatic send_query(input coord_type q, input want_type want);
      bit is_in;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 3 * COORD_W){1'b0}}, q};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      is_in = (want == WANT_MODEL) ? blade_contains(q) : (want == WANT_IN);
      pending_verdicts.push_back('{q, is_in});
   endtask

   // Stops offering and waits until every outstanding query has been answered.
   // Every query yields exactly one result, so an empty queue means the block is idle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   // Result side: random back-pressure, none during the steady stretch, and one long
   // hold-off on request so the pipeline fills and the block refuses further queries.
   initial begin
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Result checker: each accepted result is matched against the oldest open verdict.
   always @(negedge clock) begin
      verdict_type head;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            flag_error($sformatf("result inside=%0b with no query outstanding", rsp_tdata[0]));
         end else begin
            head = pending_verdicts[0];
            pending_verdicts.delete(0);
            if (rsp_tdata[0] !== head.is_in)
               flag_error($sformatf("query (%0d, %0d, %0d): expected inside=%0b, got %b",
                                    $signed(head.query.x), $signed(head.query.y),
                                    $signed(head.query.z), head.is_in, rsp_tdata[0]));
         end
      end
   end

   // Main sequence: reset, directed probes, then six random runs over different faces.
   initial begin
      probe_row_type  row;
      face_setup_type active;
      run_kind_type   kind;
      coord_type      q;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatches  = 0;
      steady      = 1'b0;
      hold_req    = 1'b0;
      for (int i = 0; i < NUM_CORNERS; i++) corner_cfg[i] = '0;
      use_full_range();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The first probes run on the cleared corners; a new face setup is loaded only once
      // the block has answered everything sent so far.
      active = CFG_ZERO;
      for (int p = 0; p < N_PROBES; p++) begin
         row = PROBES[p];
         if (row.setup != active) begin
            wait_drained();
            apply_setup(row.setup);
            active = row.setup;
         end
         q.x = row.x;
         q.y = row.y;
         q.z = row.z;
         send_query(q, row.want);
      end

      for (int r = RUN_JITTER_BOX; r <= RUN_WIDE_JITTER; r++) begin
         kind = run_kind_type'(r);
         wait_drained();
         case (kind)
            RUN_JITTER_BOX: begin
               pick_box();
               load_box(3);
            end
            RUN_SHARP_BOX: begin
               pick_box();
               load_box(0);
            end
            RUN_FULL_BOX: begin
               use_full_range();
               load_box(0);
            end
            RUN_SCATTER: begin
               // Arbitrary corners, every register bit random; nearly all points fall outside.
               use_full_range();
               for (int i = OLD_CORNER_0; i <= NEW_CORNER_3; i++)
                  program_corner(i, CORNER_REG_W'({$urandom, $urandom}));
            end
            RUN_SKEW_BOX: begin
               pick_box();
               load_box(40);
            end
            default: begin
               pick_box();
               load_box(1000);
            end
         endcase
         steady   = (kind == RUN_SKEW_BOX);
         hold_req = (kind == RUN_SHARP_BOX);
         for (int k = 0; k < RUN_LEN; k++) begin
            // Halfway through the full-range run the sender pauses until the block is empty.
            if (kind == RUN_FULL_BOX && k == RUN_LEN / 2) wait_drained();
            send_query(next_query(), WANT_MODEL);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/psbt_pkg.sv
sv/point_in_swept_blade_test.sv
sv/psbt_checker.sv
dv/point_in_swept_blade_test_test.sv
